// ----- hdl/ata_pio_lba28_host_sequencer_unit_defines.svh -----
// ----------------------------------------------------------------------------
// ATA PIO LBA28 host sequencer assertion macros
// Shared concurrent checks, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ATA_PIO_LBA28_HOST_SEQUENCER_UNIT_DEFINES_SVH
`define ATA_PIO_LBA28_HOST_SEQUENCER_UNIT_DEFINES_SVH

// same-cycle implication
`define APLHS_ASSERT_NOW(label, cond, consq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (consq)) \
    else $error(msg);

// next-cycle implication
`define APLHS_ASSERT_NEXT(label, cond, consq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (consq)) \
    else $error(msg);

`endif

// ----- hdl/aplhs_pkg.sv -----
// ----------------------------------------------------------------------------
// aplhs_pkg
// Types, codes and the result expansion table of the ATA PIO LBA28 sequencer.
// ----------------------------------------------------------------------------
package aplhs_pkg;

  localparam int WORDS_PER_SECTOR = 256;

  localparam logic [1:0] ACT_START  = 2'd0;
  localparam logic [1:0] ACT_STATUS = 2'd1;
  localparam logic [1:0] ACT_DATA   = 2'd2;

  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_POLL  = 3'd1;
  localparam logic [2:0] PH_RDATA = 3'd2;
  localparam logic [2:0] PH_WDATA = 3'd3;
  localparam logic [2:0] PH_FLUSH = 3'd4;

  localparam logic [2:0] OFF_DATA  = 3'd0;
  localparam logic [2:0] OFF_COUNT = 3'd2;
  localparam logic [2:0] OFF_LO    = 3'd3;
  localparam logic [2:0] OFF_MID   = 3'd4;
  localparam logic [2:0] OFF_HI    = 3'd5;
  localparam logic [2:0] OFF_DRIVE = 3'd6;
  localparam logic [2:0] OFF_CMD   = 3'd7;

  localparam int ST_BSY = 7;
  localparam int ST_DF  = 5;
  localparam int ST_DRQ = 3;
  localparam int ST_ERR = 0;

  localparam logic [7:0] DRIVE_LBA_MASTER = 8'hE0;
  localparam logic [7:0] CMD_READ_SECTORS = 8'h20;
  localparam logic [7:0] CMD_WRITE_SECTORS = 8'h30;
  localparam logic [7:0] CMD_CACHE_FLUSH  = 8'hE7;

  localparam logic [15:0] PORT_BASE_RESET      = 16'h01F0;
  localparam logic [7:0]  READS_PER_POLL_RESET = 8'd15;

  localparam logic CFG_PORT_BASE      = 1'b0;
  localparam logic CFG_READS_PER_POLL = 1'b1;

  localparam logic [2:0] K_BUS_WRITE = 3'd0;
  localparam logic [2:0] K_BUS_READ  = 3'd1;
  localparam logic [2:0] K_WORD      = 3'd2;
  localparam logic [2:0] K_DONE      = 3'd3;
  localparam logic [2:0] K_ERROR     = 3'd4;
  localparam logic [2:0] K_IGNORED   = 3'd5;

  localparam logic [3:0] SEQ_IGNORE       = 4'd0;
  localparam logic [3:0] SEQ_START        = 4'd1;
  localparam logic [3:0] SEQ_STATUS       = 4'd2;
  localparam logic [3:0] SEQ_ERROR        = 4'd3;
  localparam logic [3:0] SEQ_DATA_RD      = 4'd4;
  localparam logic [3:0] SEQ_DONE         = 4'd5;
  localparam logic [3:0] SEQ_RWORD_DATA   = 4'd6;
  localparam logic [3:0] SEQ_RWORD_STATUS = 4'd7;
  localparam logic [3:0] SEQ_RWORD_DONE   = 4'd8;
  localparam logic [3:0] SEQ_WWORD        = 4'd9;
  localparam logic [3:0] SEQ_WWORD_STATUS = 4'd10;
  localparam logic [3:0] SEQ_WWORD_FLUSH  = 4'd11;

  typedef struct packed {
    logic [3:0]  seq;
    logic [27:0] block_address;
    logic [7:0]  sector_total;
    logic        to_disk;
    logic [15:0] data_word;
  } job_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] port;
    logic [15:0] value;
    logic        last;
  } res_t;

  function automatic res_t seq_result(input job_t j, input logic [2:0] step,
                                      input logic [15:0] base);
    logic [2:0]  kind;
    logic [2:0]  off;
    logic [15:0] val;
    logic        lst;
    res_t        r;
    kind = K_IGNORED;
    off  = OFF_DATA;
    val  = 16'd0;
    lst  = 1'b1;
    case (j.seq)
      SEQ_START: begin
        kind = K_BUS_WRITE;
        lst  = 1'b0;
        case (step)
          3'd0: begin
            off = OFF_DRIVE;
            val = {8'd0, DRIVE_LBA_MASTER | {4'd0, j.block_address[27:24]}};
          end
          3'd1: begin
            off = OFF_COUNT;
            val = {8'd0, j.sector_total};
          end
          3'd2: begin
            off = OFF_LO;
            val = {8'd0, j.block_address[7:0]};
          end
          3'd3: begin
            off = OFF_MID;
            val = {8'd0, j.block_address[15:8]};
          end
          3'd4: begin
            off = OFF_HI;
            val = {8'd0, j.block_address[23:16]};
          end
          3'd5: begin
            off = OFF_CMD;
            val = {8'd0, j.to_disk ? CMD_WRITE_SECTORS : CMD_READ_SECTORS};
          end
          default: begin
            kind = K_BUS_READ;
            off  = OFF_CMD;
            lst  = 1'b1;
          end
        endcase
      end
      SEQ_STATUS: begin
        kind = K_BUS_READ;
        off  = OFF_CMD;
      end
      SEQ_ERROR: kind = K_ERROR;
      SEQ_DATA_RD: begin
        kind = K_BUS_READ;
        off  = OFF_DATA;
      end
      SEQ_DONE: kind = K_DONE;
      SEQ_RWORD_DATA, SEQ_RWORD_STATUS, SEQ_RWORD_DONE: begin
        if (step == 3'd0) begin
          kind = K_WORD;
          val  = j.data_word;
          lst  = 1'b0;
        end else if (j.seq == SEQ_RWORD_DATA) begin
          kind = K_BUS_READ;
          off  = OFF_DATA;
        end else if (j.seq == SEQ_RWORD_STATUS) begin
          kind = K_BUS_READ;
          off  = OFF_CMD;
        end else begin
          kind = K_DONE;
        end
      end
      SEQ_WWORD: begin
        kind = K_BUS_WRITE;
        off  = OFF_DATA;
        val  = j.data_word;
      end
      SEQ_WWORD_STATUS: begin
        if (step == 3'd0) begin
          kind = K_BUS_WRITE;
          off  = OFF_DATA;
          val  = j.data_word;
          lst  = 1'b0;
        end else begin
          kind = K_BUS_READ;
          off  = OFF_CMD;
        end
      end
      SEQ_WWORD_FLUSH: begin
        case (step)
          3'd0: begin
            kind = K_BUS_WRITE;
            off  = OFF_DATA;
            val  = j.data_word;
            lst  = 1'b0;
          end
          3'd1: begin
            kind = K_BUS_WRITE;
            off  = OFF_CMD;
            val  = {8'd0, CMD_CACHE_FLUSH};
            lst  = 1'b0;
          end
          default: begin
            kind = K_BUS_READ;
            off  = OFF_CMD;
          end
        endcase
      end
      default: kind = K_IGNORED;
    endcase
    r.kind  = kind;
    r.port  = (kind == K_BUS_WRITE || kind == K_BUS_READ) ? base + {13'd0, off} : 16'd0;
    r.value = val;
    r.last  = lst;
    return r;
  endfunction

endpackage

// ----- hdl/aplhs_jobq.sv -----
// ----------------------------------------------------------------------------
// aplhs_jobq
// Small FIFO of classified jobs between the front and back parts.
// ----------------------------------------------------------------------------
module aplhs_jobq #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  aplhs_pkg::job_t job_in,
  output logic           full,
  input  logic           pop,
  output aplhs_pkg::job_t job_out,
  output logic           empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  aplhs_pkg::job_t slots [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;
  logic            do_push;
  logic            do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign job_out = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      count <= count + CW'(do_push) - CW'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= job_in;
    end
  end

endmodule

// ----- hdl/aplhs_front.sv -----
// ----------------------------------------------------------------------------
// aplhs_front
// Accepts items, tracks the transfer phase and classifies each item into a job.
// ----------------------------------------------------------------------------
module aplhs_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  output logic            full,
  input  logic [1:0]      action,
  input  logic [27:0]     block_address,
  input  logic [7:0]      sector_total,
  input  logic            to_disk,
  input  logic [7:0]      status_byte,
  input  logic [15:0]     data_word,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic            cfg_index,
  input  logic [15:0]     cfg_data,
  output logic [15:0]     port_base,
  output logic            job_push,
  output aplhs_pkg::job_t job,
  input  logic            jq_full
);

  logic [2:0] phase, phase_next;
  logic [7:0] sectors_left, sectors_left_next;
  logic [7:0] word_index, word_index_next;
  logic [7:0] poll_reads_done, poll_reads_done_next;
  logic       writing, writing_next;
  logic [7:0] reads_per_poll;
  logic       accept;
  logic       has_job;
  logic [7:0] poll_inc;
  logic [7:0] sec_dec;
  logic       rd;

  assign full      = jq_full;
  assign cfg_ready = 1'b1;
  assign accept    = push && !jq_full;
  assign job_push  = accept && has_job;
  assign poll_inc  = poll_reads_done + 8'd1;
  assign sec_dec   = sectors_left - 8'd1;
  assign rd        = (phase == aplhs_pkg::PH_RDATA);

  always_comb begin
    phase_next           = phase;
    sectors_left_next    = sectors_left;
    word_index_next      = word_index;
    poll_reads_done_next = poll_reads_done;
    writing_next         = writing;
    has_job              = 1'b1;
    job.seq              = aplhs_pkg::SEQ_IGNORE;
    job.block_address    = block_address;
    job.sector_total     = sector_total;
    job.to_disk          = to_disk;
    job.data_word        = data_word;
    case (phase)
      aplhs_pkg::PH_IDLE: begin
        if (action == aplhs_pkg::ACT_START && sector_total != 8'd0) begin
          job.seq              = aplhs_pkg::SEQ_START;
          phase_next           = aplhs_pkg::PH_POLL;
          sectors_left_next    = sector_total;
          word_index_next      = 8'd0;
          poll_reads_done_next = 8'd0;
          writing_next         = to_disk;
        end
      end
      aplhs_pkg::PH_POLL: begin
        if (action == aplhs_pkg::ACT_STATUS) begin
          if (poll_inc < reads_per_poll) begin
            job.seq              = aplhs_pkg::SEQ_STATUS;
            poll_reads_done_next = poll_inc;
          end else begin
            poll_reads_done_next = 8'd0;
            if (status_byte[aplhs_pkg::ST_ERR] || status_byte[aplhs_pkg::ST_DF]) begin
              job.seq           = aplhs_pkg::SEQ_ERROR;
              phase_next        = aplhs_pkg::PH_IDLE;
              sectors_left_next = 8'd0;
              word_index_next   = 8'd0;
              writing_next      = 1'b0;
            end else if (!status_byte[aplhs_pkg::ST_BSY] && status_byte[aplhs_pkg::ST_DRQ]) begin
              word_index_next = 8'd0;
              if (writing) begin
                phase_next = aplhs_pkg::PH_WDATA;
                has_job    = 1'b0;
              end else begin
                phase_next = aplhs_pkg::PH_RDATA;
                job.seq    = aplhs_pkg::SEQ_DATA_RD;
              end
            end else begin
              job.seq = aplhs_pkg::SEQ_STATUS;
            end
          end
        end
      end
      aplhs_pkg::PH_RDATA, aplhs_pkg::PH_WDATA: begin
        if (action == aplhs_pkg::ACT_DATA) begin
          if (word_index == 8'(aplhs_pkg::WORDS_PER_SECTOR - 1)) begin
            word_index_next   = 8'd0;
            sectors_left_next = sec_dec;
            if (sec_dec != 8'd0) begin
              phase_next           = aplhs_pkg::PH_POLL;
              poll_reads_done_next = 8'd0;
              job.seq = rd ? aplhs_pkg::SEQ_RWORD_STATUS : aplhs_pkg::SEQ_WWORD_STATUS;
            end else if (!rd) begin
              job.seq    = aplhs_pkg::SEQ_WWORD_FLUSH;
              phase_next = aplhs_pkg::PH_FLUSH;
            end else begin
              job.seq      = aplhs_pkg::SEQ_RWORD_DONE;
              phase_next   = aplhs_pkg::PH_IDLE;
              writing_next = 1'b0;
            end
          end else begin
            word_index_next = word_index + 8'd1;
            job.seq = rd ? aplhs_pkg::SEQ_RWORD_DATA : aplhs_pkg::SEQ_WWORD;
          end
        end
      end
      aplhs_pkg::PH_FLUSH: begin
        if (action == aplhs_pkg::ACT_STATUS) begin
          if (!status_byte[aplhs_pkg::ST_BSY]) begin
            job.seq      = aplhs_pkg::SEQ_DONE;
            phase_next   = aplhs_pkg::PH_IDLE;
            writing_next = 1'b0;
          end else begin
            job.seq = aplhs_pkg::SEQ_STATUS;
          end
        end
      end
      default: job.seq = aplhs_pkg::SEQ_IGNORE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= aplhs_pkg::PH_IDLE;
      sectors_left    <= 8'd0;
      word_index      <= 8'd0;
      poll_reads_done <= 8'd0;
      writing         <= 1'b0;
      port_base       <= aplhs_pkg::PORT_BASE_RESET;
      reads_per_poll  <= aplhs_pkg::READS_PER_POLL_RESET;
    end else begin
      if (accept) begin
        phase           <= phase_next;
        sectors_left    <= sectors_left_next;
        word_index      <= word_index_next;
        poll_reads_done <= poll_reads_done_next;
        writing         <= writing_next;
      end
      if (cfg_valid) begin
        case (cfg_index)
          aplhs_pkg::CFG_PORT_BASE:      port_base <= cfg_data;
          aplhs_pkg::CFG_READS_PER_POLL: reads_per_poll <= cfg_data[7:0];
          default: ;
        endcase
      end
    end
  end

endmodule

// ----- hdl/aplhs_back.sv -----
// ----------------------------------------------------------------------------
// aplhs_back
// Expands jobs into results, one per cycle while the result queue has room.
// ----------------------------------------------------------------------------
`include "ata_pio_lba28_host_sequencer_unit_defines.svh"

module aplhs_back (
  input  logic            clk,
  input  logic            rst,
  input  aplhs_pkg::job_t job,
  input  logic            job_valid,
  output logic            job_pop,
  input  logic [15:0]     port_base,
  input  logic            pop,
  output logic            empty,
  output aplhs_pkg::res_t res_out
);

  aplhs_pkg::res_t slots [2];
  aplhs_pkg::res_t cur;
  logic [2:0]      step;
  logic [1:0]      ocount;
  logic            wr_ptr;
  logic            rd_ptr;
  logic            out_full;
  logic            emit;
  logic            opop;

  assign cur      = aplhs_pkg::seq_result(job, step, port_base);
  assign out_full = (ocount == 2'd2);
  assign empty    = (ocount == 2'd0);
  assign emit     = job_valid && !out_full;
  assign job_pop  = emit && cur.last;
  assign opop     = pop && !empty;
  assign res_out  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      step   <= 3'd0;
      ocount <= 2'd0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      if (emit) begin
        step   <= cur.last ? 3'd0 : step + 3'd1;
        wr_ptr <= !wr_ptr;
      end
      if (opop) begin
        rd_ptr <= !rd_ptr;
      end
      ocount <= ocount + 2'(emit) - 2'(opop);
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      slots[wr_ptr] <= cur;
    end
  end

  `APLHS_ASSERT_NOW(a_no_overflow, emit, ocount != 2'd2, "result queue overflow")
  `APLHS_ASSERT_NEXT(a_step_restart, emit && cur.last, step == 3'd0, "step not restarted")
  `APLHS_ASSERT_NEXT(a_drain, opop && ocount == 2'd1 && !emit, empty, "result queue not drained")

endmodule

// ----- hdl/ata_pio_lba28_host_sequencer_unit.sv -----
// ----------------------------------------------------------------------------
// ata_pio_lba28_host_sequencer_unit
// Host-side ATA PIO 28-bit LBA sequencer with queue-style item and result ports.
// ----------------------------------------------------------------------------
// An accepted item's job passes the job queue, then the result queue, before its first result is on the result ports.
// The back part emits one result per cycle while the result queue has room;
// an item yields 0 to 7 results (a start 7, a write sector's ready poll none).
// Items are taken every cycle while the job queue has room.
// Reset clears phase, counters and both queues; port_base returns to 0x1F0
// and reads_per_poll to 15.
module ata_pio_lba28_host_sequencer_unit #(
  parameter int JOB_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  action,
  input  logic [27:0] block_address,
  input  logic [7:0]  sector_total,
  input  logic        to_disk,
  input  logic [7:0]  status_byte,
  input  logic [15:0] data_word,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  kind,
  output logic [15:0] port,
  output logic [15:0] value,
  output logic        last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  aplhs_pkg::job_t job_in;
  aplhs_pkg::job_t job_head;
  aplhs_pkg::res_t res;
  logic            job_push;
  logic            jq_full;
  logic            jq_empty;
  logic            job_pop;
  logic [15:0]     port_base;

  aplhs_front u_front (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .action        (action),
    .block_address (block_address),
    .sector_total  (sector_total),
    .to_disk       (to_disk),
    .status_byte   (status_byte),
    .data_word     (data_word),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .port_base     (port_base),
    .job_push      (job_push),
    .job           (job_in),
    .jq_full       (jq_full)
  );

  aplhs_jobq #(
    .DEPTH (JOB_DEPTH)
  ) u_jobq (
    .clk     (clk),
    .rst     (rst),
    .push    (job_push),
    .job_in  (job_in),
    .full    (jq_full),
    .pop     (job_pop),
    .job_out (job_head),
    .empty   (jq_empty)
  );

  aplhs_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job       (job_head),
    .job_valid (!jq_empty),
    .job_pop   (job_pop),
    .port_base (port_base),
    .pop       (pop),
    .empty     (empty),
    .res_out   (res)
  );

  assign kind  = res.kind;
  assign port  = res.port;
  assign value = res.value;
  assign last  = res.last;

endmodule

// ----- sim/ata_pio_lba28_host_sequencer_unit_tb.sv -----
// ----------------------------------------------------------------------------
// ata_pio_lba28_host_sequencer_unit_tb
// Drives start, status and data requests into the ATA PIO LBA28 sequencer and
// checks every bus operation, host word, done and error result it emits
// against a cycle-free behavioral copy of the sequencer, with random idling on
// both queue sides, one long result stall and several register settings.
// ----------------------------------------------------------------------------
module ata_pio_lba28_host_sequencer_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES  = 20;
  localparam int HOLD_CYCLES    = 300;
  localparam int HOLD_AT_RESULT = 100;
  localparam int PREFIX_WORDS   = 12;

  typedef enum int {SESS_ERROR, SESS_READ, SESS_WRITE} session_t;
  typedef enum int {JUDGE_BUSY, JUDGE_READY, JUDGE_FAULT} judge_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [27:0] block_address;
    logic [7:0]  sector_total;
    logic        to_disk;
    logic [7:0]  status_byte;
    logic [15:0] data_word;
  } req_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic [1:0]  action = 2'd0;
  logic [27:0] block_address = 28'd0;
  logic [7:0]  sector_total = 8'd0;
  logic        to_disk = 1'b0;
  logic [7:0]  status_byte = 8'd0;
  logic [15:0] data_word = 16'd0;
  logic        empty;
  logic        pop = 1'b0;
  logic [2:0]  kind;
  logic [15:0] port;
  logic [15:0] value;
  logic        last;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = 1'b0;
  logic [15:0] cfg_data = 16'd0;

  req_t            pending_reqs[$];
  aplhs_pkg::res_t expected_ops[$];
  int              errors = 0;
  logic            quiet = 1'b0;

  logic [15:0] cfg_port_base = aplhs_pkg::PORT_BASE_RESET;
  logic [7:0]  cfg_reads_per_poll = aplhs_pkg::READS_PER_POLL_RESET;
  logic [2:0]  seq_phase = aplhs_pkg::PH_IDLE;
  logic [7:0]  sectors_left = 8'd0;
  logic [7:0]  word_index = 8'd0;
  logic [7:0]  polls_done = 8'd0;
  logic        writing = 1'b0;

  ata_pio_lba28_host_sequencer_unit u_dut (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .action        (action),
    .block_address (block_address),
    .sector_total  (sector_total),
    .to_disk       (to_disk),
    .status_byte   (status_byte),
    .data_word     (data_word),
    .empty         (empty),
    .pop           (pop),
    .kind          (kind),
    .port          (port),
    .value         (value),
    .last          (last),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void push_op(input logic [2:0] k, input logic [2:0] off,
                                  input logic [15:0] val);
    aplhs_pkg::res_t r;
    r.kind  = k;
    r.port  = (k == aplhs_pkg::K_BUS_WRITE || k == aplhs_pkg::K_BUS_READ) ?
              cfg_port_base + {13'd0, off} : 16'd0;
    r.value = val;
    r.last  = 1'b0;
    expected_ops.push_back(r);
  endfunction

  function automatic void predict_ops(input req_t r);
    int   n0;
    logic taken;
    logic reading;
    n0    = expected_ops.size();
    taken = 1'b0;
    if (seq_phase == aplhs_pkg::PH_IDLE && r.action == aplhs_pkg::ACT_START &&
        r.sector_total != 8'd0) begin
      taken = 1'b1;
      push_op(aplhs_pkg::K_BUS_WRITE, aplhs_pkg::OFF_DRIVE,
              {8'd0, aplhs_pkg::DRIVE_LBA_MASTER | {4'd0, r.block_address[27:24]}});
      push_op(aplhs_pkg::K_BUS_WRITE, aplhs_pkg::OFF_COUNT, {8'd0, r.sector_total});
      push_op(aplhs_pkg::K_BUS_WRITE, aplhs_pkg::OFF_LO, {8'd0, r.block_address[7:0]});
      push_op(aplhs_pkg::K_BUS_WRITE, aplhs_pkg::OFF_MID, {8'd0, r.block_address[15:8]});
      push_op(aplhs_pkg::K_BUS_WRITE, aplhs_pkg::OFF_HI, {8'd0, r.block_address[23:16]});
      push_op(aplhs_pkg::K_BUS_WRITE, aplhs_pkg::OFF_CMD,
              {8'd0, r.to_disk ? aplhs_pkg::CMD_WRITE_SECTORS
                               : aplhs_pkg::CMD_READ_SECTORS});
      push_op(aplhs_pkg::K_BUS_READ, aplhs_pkg::OFF_CMD, 16'd0);
      seq_phase    = aplhs_pkg::PH_POLL;
      sectors_left = r.sector_total;
      word_index   = 8'd0;
      polls_done   = 8'd0;
      writing      = r.to_disk;
    end else if (seq_phase == aplhs_pkg::PH_POLL && r.action == aplhs_pkg::ACT_STATUS) begin
      taken      = 1'b1;
      polls_done = polls_done + 8'd1;
      if (polls_done < cfg_reads_per_poll) begin
        push_op(aplhs_pkg::K_BUS_READ, aplhs_pkg::OFF_CMD, 16'd0);
      end else begin
        polls_done = 8'd0;
        if (r.status_byte[aplhs_pkg::ST_ERR] || r.status_byte[aplhs_pkg::ST_DF]) begin
          push_op(aplhs_pkg::K_ERROR, aplhs_pkg::OFF_DATA, 16'd0);
          seq_phase    = aplhs_pkg::PH_IDLE;
          sectors_left = 8'd0;
          word_index   = 8'd0;
          writing      = 1'b0;
        end else if (!r.status_byte[aplhs_pkg::ST_BSY] &&
                     r.status_byte[aplhs_pkg::ST_DRQ]) begin
          word_index = 8'd0;
          if (writing) begin
            seq_phase = aplhs_pkg::PH_WDATA;
          end else begin
            seq_phase = aplhs_pkg::PH_RDATA;
            push_op(aplhs_pkg::K_BUS_READ, aplhs_pkg::OFF_DATA, 16'd0);
          end
        end else begin
          push_op(aplhs_pkg::K_BUS_READ, aplhs_pkg::OFF_CMD, 16'd0);
        end
      end
    end else if ((seq_phase == aplhs_pkg::PH_RDATA || seq_phase == aplhs_pkg::PH_WDATA) &&
                 r.action == aplhs_pkg::ACT_DATA) begin
      taken   = 1'b1;
      reading = (seq_phase == aplhs_pkg::PH_RDATA);
      if (reading) push_op(aplhs_pkg::K_WORD, aplhs_pkg::OFF_DATA, r.data_word);
      else push_op(aplhs_pkg::K_BUS_WRITE, aplhs_pkg::OFF_DATA, r.data_word);
      if (word_index == 8'(aplhs_pkg::WORDS_PER_SECTOR - 1)) begin
        word_index   = 8'd0;
        sectors_left = sectors_left - 8'd1;
        if (sectors_left != 8'd0) begin
          seq_phase  = aplhs_pkg::PH_POLL;
          polls_done = 8'd0;
          push_op(aplhs_pkg::K_BUS_READ, aplhs_pkg::OFF_CMD, 16'd0);
        end else if (!reading) begin
          push_op(aplhs_pkg::K_BUS_WRITE, aplhs_pkg::OFF_CMD,
                  {8'd0, aplhs_pkg::CMD_CACHE_FLUSH});
          push_op(aplhs_pkg::K_BUS_READ, aplhs_pkg::OFF_CMD, 16'd0);
          seq_phase = aplhs_pkg::PH_FLUSH;
        end else begin
          push_op(aplhs_pkg::K_DONE, aplhs_pkg::OFF_DATA, 16'd0);
          seq_phase = aplhs_pkg::PH_IDLE;
          writing   = 1'b0;
        end
      end else begin
        word_index = word_index + 8'd1;
        if (reading) push_op(aplhs_pkg::K_BUS_READ, aplhs_pkg::OFF_DATA, 16'd0);
      end
    end else if (seq_phase == aplhs_pkg::PH_FLUSH && r.action == aplhs_pkg::ACT_STATUS) begin
      taken = 1'b1;
      if (!r.status_byte[aplhs_pkg::ST_BSY]) begin
        push_op(aplhs_pkg::K_DONE, aplhs_pkg::OFF_DATA, 16'd0);
        seq_phase = aplhs_pkg::PH_IDLE;
        writing   = 1'b0;
      end else begin
        push_op(aplhs_pkg::K_BUS_READ, aplhs_pkg::OFF_CMD, 16'd0);
      end
    end
    if (!taken) push_op(aplhs_pkg::K_IGNORED, aplhs_pkg::OFF_DATA, 16'd0);
    if (expected_ops.size() > n0) expected_ops[$].last = 1'b1;
  endfunction

  function automatic int pick_pct();
    case ($urandom_range(0, 2))
      0: return 0;
      1: return 10;
      default: return 35;
    endcase
  endfunction

  // request driver
  always @(posedge clk) begin : drv
    req_t cur_req;
    int   gap_left;
    int   idle_pct;
    int   drv_cycle;
    logic free;
    if (rst) begin
      push      <= 1'b0;
      gap_left  = 0;
      idle_pct  = 0;
      drv_cycle = 0;
    end else begin
      free = 1'b1;
      if (push) begin
        if (full) free = 1'b0;
        else predict_ops(cur_req);
      end
      if (drv_cycle % 64 == 0) idle_pct = quiet ? 0 : pick_pct();
      drv_cycle++;
      if (free) begin
        if (gap_left > 0) begin
          gap_left--;
          push <= 1'b0;
        end else if (!quiet && $urandom_range(0, 99) < idle_pct) begin
          gap_left = $urandom_range(0, 6);
          push <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
          cur_req = pending_reqs.pop_front();
          push          <= 1'b1;
          action        <= cur_req.action;
          block_address <= cur_req.block_address;
          sector_total  <= cur_req.sector_total;
          to_disk       <= cur_req.to_disk;
          status_byte   <= cur_req.status_byte;
          data_word     <= cur_req.data_word;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin : mon
    aplhs_pkg::res_t want;
    int              results_seen;
    int              hold_left;
    logic            hold_done;
    int              stall_left;
    int              stall_pct;
    int              mon_cycle;
    if (rst) begin
      pop <= 1'b0;
      results_seen = 0;
      hold_left    = 0;
      hold_done    = 1'b0;
      stall_left   = 0;
      stall_pct    = 0;
      mon_cycle    = 0;
    end else begin
      if (pop && !empty) begin
        if (expected_ops.size() == 0) begin
          $error("unexpected result: kind %0d port %h value %h last %0d",
                 kind, port, value, last);
          errors++;
        end else begin
          want = expected_ops.pop_front();
          if (kind !== want.kind) begin
            $error("kind: expected %0d, actual %0d", want.kind, kind);
            errors++;
          end
          if (port !== want.port) begin
            $error("port: expected %h, actual %h", want.port, port);
            errors++;
          end
          if (value !== want.value) begin
            $error("value: expected %h, actual %h", want.value, value);
            errors++;
          end
          if (last !== want.last) begin
            $error("last: expected %0d, actual %0d", want.last, last);
            errors++;
          end
        end
        results_seen++;
        if (!hold_done && results_seen == HOLD_AT_RESULT) begin
          hold_left = HOLD_CYCLES;
          hold_done = 1'b1;
        end
      end
      if (mon_cycle % 64 == 0) stall_pct = quiet ? 0 : pick_pct();
      mon_cycle++;
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        pop <= 1'b0;
      end else if (!quiet && $urandom_range(0, 99) < stall_pct) begin
        stall_left = $urandom_range(0, 6);
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  function automatic req_t mk_req(input logic [1:0] a, input logic [27:0] lba,
                                  input logic [7:0] cnt, input logic dir,
                                  input logic [7:0] st, input logic [15:0] word);
    req_t r;
    r.action        = a;
    r.block_address = lba;
    r.sector_total  = cnt;
    r.to_disk       = dir;
    r.status_byte   = st;
    r.data_word     = word;
    return r;
  endfunction

  function automatic req_t rand_req(input logic [1:0] a);
    return mk_req(a, 28'($urandom), 8'($urandom), 1'($urandom), 8'($urandom),
                  16'($urandom));
  endfunction

  function automatic int group_len();
    return (cfg_reads_per_poll == 8'd0) ? 1 : int'(cfg_reads_per_poll);
  endfunction

  // drop in an occasional request that is wrong for the given phase
  task automatic maybe_noise(input logic [2:0] ph);
    req_t r;
    if ($urandom_range(0, 19) == 0) begin
      r = rand_req(2'($urandom_range(0, 3)));
      case (ph)
        aplhs_pkg::PH_IDLE: begin
          if (r.action == aplhs_pkg::ACT_START) r.sector_total = 8'd0;
        end
        aplhs_pkg::PH_POLL: begin
          if (r.action == aplhs_pkg::ACT_STATUS) r.action = aplhs_pkg::ACT_DATA;
        end
        aplhs_pkg::PH_FLUSH: begin
          if (r.action == aplhs_pkg::ACT_STATUS) r.action = aplhs_pkg::ACT_START;
        end
        default: begin
          if (r.action == aplhs_pkg::ACT_DATA) r.action = aplhs_pkg::ACT_STATUS;
        end
      endcase
      pending_reqs.push_back(r);
    end
  endtask

  task automatic add_group(input judge_t j);
    int   i;
    req_t r;
    for (i = 1; i < group_len(); i++) begin
      maybe_noise(aplhs_pkg::PH_POLL);
      pending_reqs.push_back(rand_req(aplhs_pkg::ACT_STATUS));
    end
    maybe_noise(aplhs_pkg::PH_POLL);
    r = rand_req(aplhs_pkg::ACT_STATUS);
    case (j)
      JUDGE_BUSY: begin
        r.status_byte[aplhs_pkg::ST_ERR] = 1'b0;
        r.status_byte[aplhs_pkg::ST_DF]  = 1'b0;
        if (!r.status_byte[aplhs_pkg::ST_BSY] && r.status_byte[aplhs_pkg::ST_DRQ]) begin
          r.status_byte[aplhs_pkg::ST_BSY] = 1'b1;
        end
      end
      JUDGE_READY: begin
        r.status_byte[aplhs_pkg::ST_ERR] = 1'b0;
        r.status_byte[aplhs_pkg::ST_DF]  = 1'b0;
        r.status_byte[aplhs_pkg::ST_BSY] = 1'b0;
        r.status_byte[aplhs_pkg::ST_DRQ] = 1'b1;
      end
      default: begin
        if ($urandom_range(0, 1) == 0) r.status_byte[aplhs_pkg::ST_ERR] = 1'b1;
        else r.status_byte[aplhs_pkg::ST_DF] = 1'b1;
      end
    endcase
    pending_reqs.push_back(r);
  endtask

  task automatic run_session(input session_t sk);
    int   n;
    int   s;
    int   w;
    int   nsec;
    req_t r;
    maybe_noise(aplhs_pkg::PH_IDLE);
    r = rand_req(aplhs_pkg::ACT_START);
    if (sk == SESS_ERROR) r.sector_total = 8'($urandom_range(1, 255));
    else r.sector_total = 8'd1;
    if (sk == SESS_WRITE) r.to_disk = 1'b1;
    else if (sk == SESS_READ) r.to_disk = 1'b0;
    pending_reqs.push_back(r);
    nsec = r.sector_total;
    if (sk == SESS_ERROR) begin
      n = (group_len() <= 4) ? $urandom_range(0, 2) : 0;
      repeat (n) add_group(JUDGE_BUSY);
      add_group(JUDGE_FAULT);
    end else begin
      for (s = 0; s < nsec; s++) begin
        n = (group_len() <= 4) ? $urandom_range(0, 2) : 0;
        repeat (n) add_group(JUDGE_BUSY);
        add_group(JUDGE_READY);
        for (w = 0; w < aplhs_pkg::WORDS_PER_SECTOR; w++) begin
          maybe_noise((sk == SESS_READ) ? aplhs_pkg::PH_RDATA : aplhs_pkg::PH_WDATA);
          pending_reqs.push_back(rand_req(aplhs_pkg::ACT_DATA));
        end
      end
      if (sk == SESS_WRITE) begin
        n = $urandom_range(0, 3);
        repeat (n) begin
          maybe_noise(aplhs_pkg::PH_FLUSH);
          r = rand_req(aplhs_pkg::ACT_STATUS);
          r.status_byte[aplhs_pkg::ST_BSY] = 1'b1;
          pending_reqs.push_back(r);
        end
        maybe_noise(aplhs_pkg::PH_FLUSH);
        r = rand_req(aplhs_pkg::ACT_STATUS);
        r.status_byte[aplhs_pkg::ST_BSY] = 1'b0;
        pending_reqs.push_back(r);
      end
    end
  endtask

  // open a read and stop after the first few words of the sector
  task automatic run_partial_read(input int nwords);
    int   w;
    req_t r;
    maybe_noise(aplhs_pkg::PH_IDLE);
    r = rand_req(aplhs_pkg::ACT_START);
    r.sector_total = 8'($urandom_range(1, 255));
    r.to_disk      = 1'b0;
    pending_reqs.push_back(r);
    add_group(JUDGE_READY);
    for (w = 0; w < nwords; w++) begin
      maybe_noise(aplhs_pkg::PH_RDATA);
      pending_reqs.push_back(rand_req(aplhs_pkg::ACT_DATA));
    end
  endtask

  task automatic write_cfg(input logic idx, input logic [15:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == aplhs_pkg::CFG_PORT_BASE) cfg_port_base = data;
    else cfg_reads_per_poll = data[7:0];
  endtask

  // wait out all requests and results, then let trailing work settle
  task automatic finish_phase();
    while (pending_reqs.size() != 0 || push || expected_ops.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : stim
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    write_cfg(aplhs_pkg::CFG_PORT_BASE, 16'hFFFF);
    write_cfg(aplhs_pkg::CFG_READS_PER_POLL, 16'd1);
    pending_reqs.push_back(mk_req(aplhs_pkg::ACT_DATA, 28'd0, 8'd0, 1'b0, 8'h00, 16'hFFFF));
    pending_reqs.push_back(mk_req(aplhs_pkg::ACT_STATUS, 28'd0, 8'd0, 1'b0, 8'hFF, 16'h0000));
    pending_reqs.push_back(mk_req(ACT_UNUSED, 28'hFFFFFFF, 8'hFF, 1'b1, 8'hFF, 16'hFFFF));
    pending_reqs.push_back(mk_req(aplhs_pkg::ACT_START, 28'hFFFFFFF, 8'd0, 1'b1, 8'h00,
                                  16'h0000));
    pending_reqs.push_back(mk_req(aplhs_pkg::ACT_START, 28'hFFFFFFF, 8'hFF, 1'b0, 8'h00,
                                  16'h0000));
    pending_reqs.push_back(mk_req(aplhs_pkg::ACT_START, 28'd0, 8'd1, 1'b1, 8'h00, 16'h0000));
    pending_reqs.push_back(mk_req(aplhs_pkg::ACT_DATA, 28'd0, 8'd0, 1'b0, 8'h00, 16'h1234));
    pending_reqs.push_back(mk_req(aplhs_pkg::ACT_STATUS, 28'd0, 8'd0, 1'b0, 8'h80, 16'h0000));
    pending_reqs.push_back(mk_req(aplhs_pkg::ACT_STATUS, 28'd0, 8'd0, 1'b0, 8'h88, 16'h0000));
    pending_reqs.push_back(mk_req(aplhs_pkg::ACT_STATUS, 28'd0, 8'd0, 1'b0, 8'h00, 16'h0000));
    pending_reqs.push_back(mk_req(aplhs_pkg::ACT_STATUS, 28'd0, 8'd0, 1'b0, 8'h01, 16'h0000));
    pending_reqs.push_back(mk_req(aplhs_pkg::ACT_START, 28'd0, 8'd1, 1'b1, 8'h00, 16'h0000));
    pending_reqs.push_back(mk_req(aplhs_pkg::ACT_STATUS, 28'd0, 8'd0, 1'b0, 8'h20, 16'h0000));
    pending_reqs.push_back(mk_req(aplhs_pkg::ACT_START, 28'h0A5A5A5, 8'h80, 1'b0, 8'h00,
                                  16'h0000));
    pending_reqs.push_back(mk_req(aplhs_pkg::ACT_STATUS, 28'd0, 8'd0, 1'b0, 8'hFF, 16'h0000));
    finish_phase();

    write_cfg(aplhs_pkg::CFG_PORT_BASE, 16'h0000);
    write_cfg(aplhs_pkg::CFG_READS_PER_POLL, 16'd0);
    repeat (3) run_session(SESS_ERROR);
    finish_phase();

    write_cfg(aplhs_pkg::CFG_PORT_BASE, aplhs_pkg::PORT_BASE_RESET);
    write_cfg(aplhs_pkg::CFG_READS_PER_POLL, 16'd5);
    run_session(SESS_ERROR);
    finish_phase();

    write_cfg(aplhs_pkg::CFG_PORT_BASE, 16'($urandom));
    write_cfg(aplhs_pkg::CFG_READS_PER_POLL, 16'($urandom_range(2, 5)));
    run_session(SESS_WRITE);
    finish_phase();

    quiet = 1'b1;
    write_cfg(aplhs_pkg::CFG_PORT_BASE, 16'($urandom));
    write_cfg(aplhs_pkg::CFG_READS_PER_POLL, 16'd3);
    repeat (2) run_session(SESS_ERROR);
    run_partial_read(PREFIX_WORDS);
    finish_phase();

    if (errors == 0 && expected_ops.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin : watchdog
    #5ms;
    $display("status: fail");
    $finish;
  end

endmodule
